// ===== rtl/core/jsu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the JSON string unescaper.
// No dependencies; imported by the step logic, output register, top level and checker.
package jsu_pkg;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_STR  = 3'd1,
		PH_ESC  = 3'd2,
		PH_HEX1 = 3'd3,
		PH_HEX2 = 3'd4,
		PH_HEX3 = 3'd5,
		PH_HEX4 = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_CHAR = 2'd0,
		ST_DONE = 2'd1,
		ST_ERR  = 2'd2
	} status_t;

	localparam logic [7:0]  REPL_RESET = 8'h3F;
	localparam logic [7:0]  CH_QUOTE   = 8'h22;
	localparam logic [7:0]  CH_BSLASH  = 8'h5C;
	localparam logic [7:0]  CH_SLASH   = 8'h2F;
	localparam logic [7:0]  CH_CTRL_LT = 8'h20;
	localparam logic [15:0] ASCII_MAX  = 16'h007F;

	typedef struct packed {
		logic       has_res;
		logic [7:0] ch;
		status_t    st;
	} step_res_t;

endpackage

// ===== rtl/core/jsu_step.sv =====
`timescale 1ns / 1ps
// Per-byte decode logic: next phase, next hex accumulator and the optional result.
// Purely combinational; depends on jsu_pkg.
module jsu_step import jsu_pkg::*; (
	input  phase_t      phase,
	input  logic [15:0] hex_accum,
	input  logic [7:0]  in_byte,
	input  logic        end_of_input,
	input  logic [7:0]  replacement_char,
	output phase_t      phase_nxt,
	output logic [15:0] hex_accum_nxt,
	output step_res_t   res
);

	// Bit 4 set means the byte is not a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] v;
		v = 5'h10;
		if (b inside {[8'h30:8'h39]}) begin
			v = {1'b0, 4'(b - 8'h30)};
		end else if (b inside {[8'h61:8'h66]}) begin
			v = {1'b0, 4'(b - 8'h57)};
		end else if (b inside {[8'h41:8'h46]}) begin
			v = {1'b0, 4'(b - 8'h37)};
		end
		return v;
	endfunction

	logic [4:0]  hv;
	logic [15:0] acc_shift;

	assign hv        = hex_value(in_byte);
	assign acc_shift = {hex_accum[11:0], hv[3:0]};

	always_comb begin
		phase_nxt     = phase;
		hex_accum_nxt = hex_accum;
		res           = '{has_res: 1'b0, ch: 8'h00, st: ST_CHAR};

		if (end_of_input && phase != PH_IDLE) begin
			phase_nxt     = PH_IDLE;
			hex_accum_nxt = '0;
			res           = '{has_res: 1'b1, ch: 8'h00, st: ST_ERR};
		end else begin
			case (phase)
				PH_IDLE: begin
					if (end_of_input || in_byte != CH_QUOTE) begin
						hex_accum_nxt = '0;
						res           = '{has_res: 1'b1, ch: 8'h00, st: ST_ERR};
					end else begin
						phase_nxt = PH_STR;
					end
				end
				PH_STR: begin
					if (in_byte == CH_QUOTE) begin
						phase_nxt = PH_IDLE;
						res       = '{has_res: 1'b1, ch: 8'h00, st: ST_DONE};
					end else if (in_byte == CH_BSLASH) begin
						phase_nxt = PH_ESC;
					end else if (in_byte < CH_CTRL_LT) begin
						phase_nxt     = PH_IDLE;
						hex_accum_nxt = '0;
						res           = '{has_res: 1'b1, ch: 8'h00, st: ST_ERR};
					end else begin
						res = '{has_res: 1'b1, ch: in_byte, st: ST_CHAR};
					end
				end
				PH_ESC: begin
					phase_nxt = PH_STR;
					case (in_byte)
						CH_QUOTE, CH_BSLASH, CH_SLASH:
							res = '{has_res: 1'b1, ch: in_byte, st: ST_CHAR};
						8'h62: res = '{has_res: 1'b1, ch: 8'h08, st: ST_CHAR};
						8'h66: res = '{has_res: 1'b1, ch: 8'h0C, st: ST_CHAR};
						8'h6E: res = '{has_res: 1'b1, ch: 8'h0A, st: ST_CHAR};
						8'h72: res = '{has_res: 1'b1, ch: 8'h0D, st: ST_CHAR};
						8'h74: res = '{has_res: 1'b1, ch: 8'h09, st: ST_CHAR};
						8'h75: begin
							phase_nxt     = PH_HEX1;
							hex_accum_nxt = '0;
						end
						default: begin
							phase_nxt     = PH_IDLE;
							hex_accum_nxt = '0;
							res           = '{has_res: 1'b1, ch: 8'h00, st: ST_ERR};
						end
					endcase
				end
				PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
					if (hv[4]) begin
						phase_nxt     = PH_IDLE;
						hex_accum_nxt = '0;
						res           = '{has_res: 1'b1, ch: 8'h00, st: ST_ERR};
					end else begin
						hex_accum_nxt = acc_shift;
						if (phase == PH_HEX4) begin
							phase_nxt = PH_STR;
							// Codes outside the ASCII range collapse to one configured byte.
							if (acc_shift <= ASCII_MAX) begin
								res = '{has_res: 1'b1, ch: acc_shift[7:0], st: ST_CHAR};
							end else begin
								res = '{has_res: 1'b1, ch: replacement_char, st: ST_CHAR};
							end
						end else begin
							phase_nxt = phase_t'(phase + 3'd1);
						end
					end
				end
				default: begin
					phase_nxt     = PH_IDLE;
					hex_accum_nxt = '0;
					res           = '{has_res: 1'b1, ch: 8'h00, st: ST_ERR};
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/jsu_out_reg.sv =====
`timescale 1ns / 1ps
// Result register with valid/stall handshake toward the consumer.
// Depends on jsu_pkg for the result type.
module jsu_out_reg import jsu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  step_res_t res,
	input  logic      rsp_stall,
	output logic      rsp_valid,
	output logic      free,
	output logic [7:0] out_char,
	output logic [1:0] status
);

	logic       valid_q;
	logic [7:0] char_q;
	status_t    status_q;

	// The slot can take a new result when empty or when its contents leave this cycle.
	assign free = !valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load || (valid_q && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q   <= res.ch;
			status_q <= res.st;
		end
	end

	assign rsp_valid = valid_q;
	assign out_char  = char_q;
	assign status    = status_q;

endmodule

// ===== rtl/core/json_string_unescaper_core.sv =====
`timescale 1ns / 1ps
// JSON string unescaper top level: input register, decode step, result register.
// Depends on jsu_pkg, jsu_step and jsu_out_reg.
// Each accepted byte is held in the input register, decoded, and its result is presented from the result register.
// Throughput: one request per cycle, except while a result waits on a stalled consumer (req_stall).
// Reset (arst_n low, asynchronous): idle awaiting an opening quote, replacement byte 0x3F.
module json_string_unescaper_core import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_input,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [7:0] out_char,
	output logic [1:0] status,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eoi_s1;
	phase_t      phase_q;
	logic [15:0] accum_q;
	logic [7:0]  repl_q;

	phase_t      phase_nxt;
	logic [15:0] accum_nxt;
	step_res_t   res;
	logic        out_free;
	logic        adv;
	logic        accept;

	jsu_step u_step (
		.phase            (phase_q),
		.hex_accum        (accum_q),
		.in_byte          (byte_s1),
		.end_of_input     (eoi_s1),
		.replacement_char (repl_q),
		.phase_nxt        (phase_nxt),
		.hex_accum_nxt    (accum_nxt),
		.res              (res)
	);

	// A byte that yields no result always moves on; one with a result needs a free slot.
	assign adv       = valid_s1 && (!res.has_res || out_free);
	assign req_stall = valid_s1 && !adv;
	assign accept    = req_valid && !req_stall;

	jsu_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && res.has_res),
		.res       (res),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.free      (out_free),
		.out_char  (out_char),
		.status    (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_IDLE;
			accum_q  <= '0;
			repl_q   <= REPL_RESET;
		end else begin
			valid_s1 <= accept || (valid_s1 && !adv);
			if (adv) begin
				phase_q <= phase_nxt;
				accum_q <= accum_nxt;
			end
			if (cfg_we) begin
				repl_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			eoi_s1  <= end_of_input;
		end
	end

endmodule

// ===== rtl/core/jsu_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg and json_string_unescaper_core.
module jsu_checker import jsu_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_stall,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input logic [7:0] out_char,
	input logic [1:0] status
);

	// A stalled result request must stay presented with the same contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(out_char) && $stable(status))
		else $error("stalled result request changed or dropped");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == ST_CHAR || status == ST_DONE || status == ST_ERR))
		else $error("illegal status code");

	// Completion and error requests carry a zero character.
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_CHAR |-> out_char == 8'h00)
		else $error("non-character result request with nonzero byte");

	// Requests are only held off when a result is waiting on the consumer.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without downstream backpressure");

endmodule

bind json_string_unescaper_core jsu_checker u_jsu_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for json_string_unescaper_core: a directed table, then random strings.
// Depends on jsu_pkg and the core; a built-in decoder predicts each result unless a typed table row gives its own.
module tb_top;
	import jsu_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAB_ROWS = 27;

	localparam logic [7:0] ESC_B = "b";
	localparam logic [7:0] ESC_F = "f";
	localparam logic [7:0] ESC_N = "n";
	localparam logic [7:0] ESC_R = "r";
	localparam logic [7:0] ESC_T = "t";
	localparam logic [7:0] ESC_U = "u";
	localparam logic [63:0] SIMPLE_ESC = {CH_QUOTE, CH_BSLASH, CH_SLASH,
		ESC_B, ESC_F, ESC_N, ESC_R, ESC_T};

	typedef struct packed {
		logic [7:0] ch;
		status_t    st;
	} res_t;

	typedef struct packed {
		logic [7:0] b;
		logic       eoi;
		logic       typed;
		logic       has;
		res_t       want;
	} row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	logic [7:0] in_byte = 8'h00;
	logic       end_of_input = 1'b0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	logic [7:0] out_char;
	logic [1:0] status;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;

	// Decoder state mirrored by the testbench.
	phase_t      dec_phase = PH_IDLE;
	logic [15:0] code_acc = '0;
	logic [7:0]  repl_byte = REPL_RESET;

	res_t exp_chars[$];
	row_t dir_tab [TAB_ROWS];
	res_t got;
	int   errors = 0;
	int   cycles = 0;
	int   sent = 0;
	int   burst_left = 0;

	json_string_unescaper_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.in_byte     (in_byte),
		.end_of_input(end_of_input),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.out_char    (out_char),
		.status      (status),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 5'(c - "0");
		if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
		if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
		return 5'd16;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 10) return 8'("0" + v);
		return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
	endfunction

	function automatic logic is_escape(input logic [7:0] c);
		case (c)
			CH_QUOTE, CH_BSLASH, CH_SLASH, ESC_B, ESC_F, ESC_N, ESC_R, ESC_T, ESC_U: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Advances the mirrored decoder by one request and returns its result, if any.
	function automatic void decode_byte(input logic [7:0] b, input logic eoi,
			output logic has, output res_t r);
		logic       bad;
		logic [4:0] hv;
		has = 1'b0;
		bad = 1'b0;
		r.ch = 8'h00;
		r.st = ST_CHAR;
		if (dec_phase == PH_IDLE) begin
			if (eoi || b != CH_QUOTE)
				bad = 1'b1;
			else
				dec_phase = PH_STR;
		end else if (eoi) begin
			bad = 1'b1;
		end else begin
			case (dec_phase)
				PH_STR: begin
					if (b == CH_QUOTE) begin
						dec_phase = PH_IDLE;
						has = 1'b1;
						r.st = ST_DONE;
					end else if (b == CH_BSLASH) begin
						dec_phase = PH_ESC;
					end else if (b < CH_CTRL_LT) begin
						bad = 1'b1;
					end else begin
						has = 1'b1;
						r.ch = b;
					end
				end
				PH_ESC: begin
					dec_phase = PH_STR;
					has = 1'b1;
					case (b)
						CH_QUOTE, CH_BSLASH, CH_SLASH: r.ch = b;
						ESC_B: r.ch = 8'h08;
						ESC_F: r.ch = 8'h0C;
						ESC_N: r.ch = 8'h0A;
						ESC_R: r.ch = 8'h0D;
						ESC_T: r.ch = 8'h09;
						ESC_U: begin
							has = 1'b0;
							code_acc = '0;
							dec_phase = PH_HEX1;
						end
						default: bad = 1'b1;
					endcase
				end
				PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
					hv = hex_digit(b);
					if (hv[4]) begin
						bad = 1'b1;
					end else begin
						code_acc = {code_acc[11:0], hv[3:0]};
						if (dec_phase != PH_HEX4) begin
							dec_phase = phase_t'(dec_phase + 3'd1);
						end else begin
							dec_phase = PH_STR;
							has = 1'b1;
							r.ch = (code_acc <= ASCII_MAX) ? code_acc[7:0] : repl_byte;
						end
					end
				end
				default: bad = 1'b1;
			endcase
		end
		if (bad) begin
			dec_phase = PH_IDLE;
			code_acc = '0;
			has = 1'b1;
			r.ch = 8'h00;
			r.st = ST_ERR;
		end
	endfunction

	task automatic report(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		errors++;
	endtask

	// Entered and left at a falling edge. A typed row overrides the predicted result.
	task automatic send_item(input row_t row);
		logic has;
		res_t r;
		int   gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		req_valid <= 1'b1;
		in_byte <= row.b;
		end_of_input <= row.eoi;
		do @(posedge clk); while (req_stall);
		decode_byte(row.b, row.eoi, has, r);
		if (row.typed) begin
			has = row.has;
			r = row.want;
		end
		if (has)
			exp_chars = {exp_chars, r};
		burst_left--;
		sent++;
		@(negedge clk);
	endtask

	task automatic send_raw(input logic [7:0] b, input logic eoi);
		row_t row;
		row = '0;
		row.b = b;
		row.eoi = eoi;
		send_item(row);
	endtask

	// Mostly well-formed strings with random content; some idle noise and broken endings.
	task automatic send_random_string();
		int         kind;
		int         t;
		int         k;
		logic       low_code;
		logic [7:0] c;
		logic [4:0] hv;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			send_raw(8'($urandom), 1'($urandom));
			return;
		end
		send_raw(CH_QUOTE, 1'b0);
		repeat ($urandom_range(0, 10)) begin
			t = $urandom_range(0, 99);
			if (t < 50) begin
				do c = 8'($urandom);
				while (c < CH_CTRL_LT || c == CH_QUOTE || c == CH_BSLASH);
				send_raw(c, 1'b0);
			end else if (t < 75) begin
				send_raw(CH_BSLASH, 1'b0);
				send_raw(SIMPLE_ESC[8 * $urandom_range(0, 7) +: 8], 1'b0);
			end else begin
				send_raw(CH_BSLASH, 1'b0);
				send_raw(ESC_U, 1'b0);
				low_code = 1'($urandom);
				for (k = 0; k < 4; k++) begin
					if (low_code && k < 2)
						send_raw(hex_char(4'd0), 1'b0);
					else if (low_code && k == 2)
						send_raw(hex_char(4'($urandom_range(0, 7))), 1'b0);
					else
						send_raw(hex_char(4'($urandom)), 1'b0);
				end
			end
		end
		if (kind < 80) begin
			send_raw(CH_QUOTE, 1'b0);
		end else begin
			case ($urandom_range(0, 3))
				0: send_raw(8'($urandom_range(0, 31)), 1'b0);
				1: begin
					send_raw(CH_BSLASH, 1'b0);
					do c = 8'($urandom); while (is_escape(c));
					send_raw(c, 1'b0);
				end
				2: begin
					send_raw(CH_BSLASH, 1'b0);
					send_raw(ESC_U, 1'b0);
					repeat ($urandom_range(0, 3)) send_raw(hex_char(4'($urandom)), 1'b0);
					do begin
						c = 8'($urandom);
						hv = hex_digit(c);
					end while (!hv[4]);
					send_raw(c, 1'b0);
				end
				default: send_raw(8'($urandom), 1'b1);
			endcase
		end
	endtask

	// Holds requests off until every outstanding result has been taken.
	task automatic drain();
		req_valid <= 1'b0;
		burst_left = 0;
		while (exp_chars.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_repl(input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		repl_byte = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// The receiver alternates between no stalls, random stalls and a fixed duty pattern.
	initial begin
		int mode;
		int mode_left;
		mode = 0;
		mode_left = 0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(32, 200);
			end
			mode_left--;
			case (mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 3) == 0);
				default: rsp_stall <= ((mode_left % 8) < 5);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (exp_chars.size() == 0) begin
				report($sformatf("result with nothing outstanding: char %02h status %0d",
					out_char, status));
			end else begin
				got = exp_chars.pop_front();
				if (out_char !== got.ch)
					report($sformatf("out_char %02h, expected %02h", out_char, got.ch));
				if (status !== got.st)
					report($sformatf("status %0d, expected %0d", status, got.st));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int         ph;
		int         target;
		logic       paused;
		logic [7:0] v;
		dir_tab = '{
			'{8'h61, 1'b0, 1'b1, 1'b1, '{8'h00, ST_ERR}},   // no opening quote
			'{8'h00, 1'b1, 1'b1, 1'b1, '{8'h00, ST_ERR}},   // end of input while idle
			'{8'h22, 1'b0, 1'b1, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h20, 1'b0, 1'b1, 1'b1, '{8'h20, ST_CHAR}},  // lowest plain byte
			'{8'hFF, 1'b0, 1'b1, 1'b1, '{8'hFF, ST_CHAR}},  // high bytes pass through
			'{8'h1F, 1'b0, 1'b1, 1'b1, '{8'h00, ST_ERR}},   // control byte
			'{8'h22, 1'b0, 1'b1, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h5C, 1'b0, 1'b1, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h6E, 1'b0, 1'b0, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h5C, 1'b0, 1'b1, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h75, 1'b0, 1'b1, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h30, 1'b0, 1'b0, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h30, 1'b0, 1'b0, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h37, 1'b0, 1'b0, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h46, 1'b0, 1'b0, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h5C, 1'b0, 1'b0, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h75, 1'b0, 1'b0, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h46, 1'b0, 1'b0, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h66, 1'b0, 1'b0, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h61, 1'b0, 1'b0, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h41, 1'b0, 1'b0, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h5C, 1'b0, 1'b0, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h78, 1'b0, 1'b1, 1'b1, '{8'h00, ST_ERR}},   // unknown escape letter
			'{8'h22, 1'b0, 1'b1, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h00, 1'b1, 1'b1, 1'b1, '{8'h00, ST_ERR}},   // input ends inside a string
			'{8'h22, 1'b0, 1'b1, 1'b0, '{8'h00, ST_CHAR}},
			'{8'h22, 1'b0, 1'b1, 1'b1, '{8'h00, ST_DONE}}   // empty string
		};
		paused = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < TAB_ROWS; i++)
			send_item(dir_tab[i]);

		for (ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0: v = 8'h00;
				1: v = 8'hFF;
				default: v = 8'($urandom);
			endcase
			write_repl(v);
			target = sent + 230;
			while (sent < target) begin
				send_random_string();
				if (ph == 1 && !paused && sent >= target - 115) begin
					drain();
					paused = 1'b1;
				end
			end
		end
		drain();

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/jsu_pkg.sv
rtl/core/jsu_step.sv
rtl/core/jsu_out_reg.sv
rtl/core/json_string_unescaper_core.sv
rtl/core/jsu_checker.sv
tb/sv/tb_top.sv
